// ===== src/tsmc_pkg.sv =====
package tsmc_pkg;

    // Default window depth; the top level may override it
    localparam int PATTERN_MAX_DEF = 16;

    // Pattern register bank: two 64-bit words, 16 bytes
    localparam int PAT_BYTES  = 16;
    localparam int PAT_W      = 8 * PAT_BYTES;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int PLEN_W     = 5;
    localparam int COUNT_W    = 32;
    // Wide enough for any pattern index the window can ask for (depth up to 64)
    localparam int PIDX_W     = 7;

    typedef logic [7:0]         t_byte;
    typedef logic [COUNT_W-1:0] t_count;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

    // Special bytes
    localparam t_byte BYTE_NUL     = 8'h00;
    localparam t_byte BYTE_SPACE   = 8'h20;
    localparam t_byte BYTE_COMMA   = 8'h2C;
    localparam t_byte BYTE_PERIOD  = 8'h2E;
    localparam t_byte BYTE_HYPHEN  = 8'h2D;
    localparam t_byte BYTE_NEWLINE = 8'h0A;

    localparam t_count COUNT_MAX = '1;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [PLEN_W-1:0] length;
    } t_cfg;

    typedef struct packed {
        t_byte data_byte;
        logic  file_start;
        logic  clear_count;
    } t_item;

    typedef struct packed {
        logic   token_hit;
        t_count match_count;
        logic   token_active;
    } t_result;

    function automatic logic is_delim(input t_byte b);
        return (b == BYTE_NUL) || (b == BYTE_SPACE) || (b == BYTE_COMMA) ||
               (b == BYTE_PERIOD) || (b == BYTE_HYPHEN);
    endfunction

endpackage

// ===== src/tsmc_in_if.sv =====
interface tsmc_in_if;
    logic             valid;
    logic             ready;
    tsmc_pkg::t_byte  data_byte;
    logic             file_start;
    logic             clear_count;

    modport source (output valid, output data_byte, output file_start,
                    output clear_count, input ready);
    modport sink   (input valid, input data_byte, input file_start,
                    input clear_count, output ready);
endinterface

// ===== src/tsmc_out_if.sv =====
interface tsmc_out_if;
    logic             valid;
    logic             ready;
    logic             token_hit;
    tsmc_pkg::t_count match_count;
    logic             token_active;

    modport source (output valid, output token_hit, output match_count,
                    output token_active, input ready);
    modport sink   (input valid, input token_hit, input match_count,
                    input token_active, output ready);
endinterface

// ===== src/tsmc_cfg_regs.sv =====
module tsmc_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tsmc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tsmc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output tsmc_pkg::t_cfg                       o_cfg
);
    import tsmc_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [PLEN_W-1:0]     r_pat_len;

    // Register bank; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_wdata;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg_wdata;
                CFG_PATTERN_LEN:  r_pat_len  <= i_cfg_wdata[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.pattern = {r_pat_high, r_pat_low};
    assign o_cfg.length  = r_pat_len;

endmodule

// ===== src/tsmc_token_core.sv =====
module tsmc_token_core #(
    parameter int PATTERN_MAX = tsmc_pkg::PATTERN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsmc_pkg::t_cfg    i_cfg,
    input  logic              i_step,
    input  tsmc_pkg::t_item   i_item,
    output tsmc_pkg::t_result o_res
);
    import tsmc_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    // History depth: the newest byte comes straight from the item
    localparam int RD = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

    // Token state
    t_byte          r_recent [RD];
    logic [LW-1:0]  r_tok_len;
    logic           r_matched;
    t_count         r_count;

    logic [LW-1:0]  n_tok_len;
    logic           n_matched;
    t_count         n_count;

    t_byte          pat [PAT_BYTES];
    t_byte          win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] lane_ok;
    logic [LW-1:0]  len_eff;
    logic [LW-1:0]  tl0;
    logic [LW-1:0]  tl1;
    logic           m0;
    t_count         cnt0;
    logic           delim;
    logic           match;
    logic           hit;

    // Split pattern words into bytes
    for (genvar g = 0; g < PAT_BYTES; g++) begin : g_pat
        assign pat[g] = i_cfg.pattern[8*g +: 8];
    end

    // Window as it stands after this byte, newest first
    assign win[0] = i_item.data_byte;
    for (genvar g = 1; g < PATTERN_MAX; g++) begin : g_win
        assign win[g] = r_recent[g-1];
    end

    // Pattern length clamped to the window depth
    always_comb begin
        if (int'(i_cfg.length) > PATTERN_MAX) begin
            len_eff = LW'(PATTERN_MAX);
        end else begin
            len_eff = LW'(i_cfg.length);
        end
    end

    // Parallel lane compare: lane i checks pattern byte len-1-i
    always_comb begin
        logic [LW-1:0]     k;
        logic [PIDX_W-1:0] kx;
        t_byte             pb;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            k  = len_eff - LW'(1) - LW'(i);
            kx = PIDX_W'(k);
            pb = (kx < PIDX_W'(PAT_BYTES)) ? pat[kx[3:0]] : BYTE_NUL;
            lane_ok[i] = (LW'(i) >= len_eff) || (win[i] == pb);
        end
    end

    // Token bookkeeping for this byte
    always_comb begin
        cnt0  = i_item.clear_count ? '0 : r_count;
        tl0   = i_item.file_start ? '0 : r_tok_len;
        m0    = i_item.file_start ? 1'b0 : r_matched;
        delim = is_delim(i_item.data_byte);
        tl1   = (tl0 == LW'(PATTERN_MAX)) ? tl0 : tl0 + LW'(1);
        match = (len_eff == '0) || ((tl1 >= len_eff) && (&lane_ok));
        hit   = !delim && !m0 && match;

        n_count = (hit && (cnt0 != COUNT_MAX)) ? cnt0 + t_count'(1) : cnt0;

        if (delim || (i_item.data_byte == BYTE_NEWLINE)) begin
            n_tok_len = '0;
            n_matched = 1'b0;
        end else begin
            n_tok_len = tl1;
            n_matched = m0 | hit;
        end

        o_res.token_hit    = hit;
        o_res.match_count  = n_count;
        o_res.token_active = !delim && (i_item.data_byte != BYTE_NEWLINE);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_len <= '0;
            r_matched <= 1'b0;
            r_count   <= '0;
        end else if (i_step) begin
            r_tok_len <= n_tok_len;
            r_matched <= n_matched;
            r_count   <= n_count;
        end
    end

    // Byte history; only bytes inside the current token are ever compared
    always_ff @(posedge i_clk) begin
        if (i_step && !delim) begin
            r_recent[0] <= i_item.data_byte;
            for (int j = 1; j < RD; j++) begin
                r_recent[j] <= r_recent[j-1];
            end
        end
    end

    // A token that already matched never reports another hit
    a_one_hit_per_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_matched && !i_item.file_start |-> !o_res.token_hit)
        else $error("second hit inside one token");

    // Count only moves up unless cleared, and by at most one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.clear_count |=>
            (r_count == $past(r_count)) || (r_count == $past(r_count) + t_count'(1)))
        else $error("match count jumped");

    // A matched token is never empty
    a_matched_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched |-> (r_tok_len != '0))
        else $error("matched flag set with no open token");

endmodule

// ===== src/token_substring_match_counter.sv =====
// Channel  Dir  Beat fields                               Handshake
// s_in     in   data_byte, file_start, clear_count        valid/ready
// m_out    out  token_hit, match_count, token_active      valid/ready
// cfg      in   i_cfg_idx, i_cfg_wdata                    i_cfg_we
//
// One result beat per input beat; each accepted beat passes the input register,
// then the token logic into the result register.
// Throughput is one byte per cycle unless the output stalls.
// Reset is synchronous, active low; pattern registers and count clear to zero.
// A stalled output holds its beat while one more input beat can still be taken.
module token_substring_match_counter #(
    parameter int PATTERN_MAX = tsmc_pkg::PATTERN_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tsmc_in_if.sink                           s_in,
    tsmc_out_if.source                        m_out,
    input  logic                              i_cfg_we,
    input  logic [tsmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tsmc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import tsmc_pkg::*;

    t_cfg    cfg;
    t_item   r_s1_item;
    logic    r_s1_v;
    t_result r_out_res;
    logic    r_out_v;
    t_result core_res;
    logic    out_free;
    logic    step;

    tsmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tsmc_token_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_item  (r_s1_item),
        .o_res   (core_res)
    );

    // Stage handshakes
    assign out_free   = !r_out_v || m_out.ready;
    assign step       = r_s1_v && out_free;
    assign s_in.ready = !r_s1_v || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s_in.valid && s_in.ready) begin
            r_s1_v <= 1'b1;
        end else if (step) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) begin
            r_s1_item.data_byte   <= s_in.data_byte;
            r_s1_item.file_start  <= s_in.file_start;
            r_s1_item.clear_count <= s_in.clear_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (step) begin
            r_out_v <= 1'b1;
        end else if (m_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= core_res;
        end
    end

    assign m_out.valid        = r_out_v;
    assign m_out.token_hit    = r_out_res.token_hit;
    assign m_out.match_count  = r_out_res.match_count;
    assign m_out.token_active = r_out_res.token_active;

endmodule

// ===== sim/token_substring_match_counter_tb.sv =====
module token_substring_match_counter_tb;
    import tsmc_pkg::*;

    localparam int WIN          = PATTERN_MAX_DEF;
    localparam int N_PHASES     = 10;
    localparam int PHASE_BYTES  = 130;
    localparam int DRAIN_CYCLES = 4;
    localparam int RUN_LIMIT    = 2_000_000;

    // receiver stall styles
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_CHOKE} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    tsmc_in_if  in_ch ();
    tsmc_out_if out_ch ();

    token_substring_match_counter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (in_ch),
        .m_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the block: pattern registers and token state
    logic [PAT_W-1:0]  cfg_pattern = '0;
    logic [PLEN_W-1:0] cfg_len     = '0;
    t_byte             win_bytes [WIN];
    logic [PLEN_W-1:0] tok_len     = '0;
    logic              tok_done    = 1'b0;
    t_count            run_count   = '0;

    t_result pending_results [$];
    int      mismatch_cnt = 0;
    int      beats_seen   = 0;
    int      bytes_sent   = 0;
    int      burst_left   = 0;

    t_rx_mode   rx_mode   = RX_FREE;
    int         rx_left   = 0;
    logic [7:0] rx_bits   = 8'hFF;

    initial win_bytes = '{default: '0};

    function automatic logic is_separator(input t_byte b);
        case (b)
            BYTE_NUL, BYTE_SPACE, BYTE_COMMA, BYTE_PERIOD, BYTE_HYPHEN: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void drop_token();
        win_bytes = '{default: '0};
        tok_len   = '0;
        tok_done  = 1'b0;
    endfunction

    // next result for one byte; advances the shadow state
    function automatic t_result predict_token_byte(input t_byte b, input logic fs,
                                                   input logic cc);
        t_result r;
        int      n;
        logic    hit_now;
        r = '0;
        if (cc)
            run_count = '0;
        if (fs)
            drop_token();
        if (is_separator(b)) begin
            drop_token();
        end else begin
            for (int i = WIN - 1; i > 0; i--)
                win_bytes[i] = win_bytes[i-1];
            win_bytes[0] = b;
            if (tok_len < WIN)
                tok_len++;
            n = (cfg_len > WIN) ? WIN : int'(cfg_len);
            hit_now = !tok_done && (tok_len >= n);
            // newest byte lines up with the last pattern byte
            for (int i = 0; i < n; i++)
                if (win_bytes[i] != cfg_pattern[8*(n-1-i) +: 8])
                    hit_now = 1'b0;
            if (hit_now) begin
                tok_done    = 1'b1;
                r.token_hit = 1'b1;
                if (run_count != COUNT_MAX)
                    run_count++;
            end
            if (b == BYTE_NEWLINE)
                drop_token();
            else
                r.token_active = 1'b1;
        end
        r.match_count = run_count;
        return r;
    endfunction

    function automatic logic flag(input int odds);
        return ($urandom_range(0, odds - 1) == 0);
    endfunction

    // word material: mostly pattern bytes, else a few letters
    function automatic t_byte text_byte();
        int n;
        n = (cfg_len > WIN) ? WIN : int'(cfg_len);
        if (n != 0 && $urandom_range(0, 2) != 0)
            return cfg_pattern[8*$urandom_range(0, n - 1) +: 8];
        return t_byte'("a") + t_byte'($urandom_range(0, 3));
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch beat %0d %s: got %0h want %0h", beats_seen, what, got, want);
        mismatch_cnt++;
    endtask

    // one beat into the block, with bursts and random gaps; call at a falling edge
    task automatic send_byte(input t_byte b, input logic fs, input logic cc);
        int gap;
        if (burst_left == 0) begin
            burst_left = flag(10) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            gap = flag(4) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap != 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_ch.valid       = 1'b1;
        in_ch.data_byte   = b;
        in_ch.file_start  = fs;
        in_ch.clear_count = cc;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        pending_results.push_back(predict_token_byte(b, fs, cc));
        burst_left--;
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic set_pattern(input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] len);
        drain_results();
        cfg_write(CFG_PATTERN_LOW, pat[63:0]);
        cfg_write(CFG_PATTERN_HIGH, pat[127:64]);
        cfg_write(CFG_PATTERN_LEN, CFG_DATA_W'(len));
        cfg_pattern = pat;
        cfg_len     = len;
    endtask

    // reset pattern is empty: every token counts on its first byte
    task automatic test_empty_pattern();
        send_byte("a", 1'b0, 1'b1);
        send_byte(BYTE_SPACE, 1'b0, 1'b0);
        send_byte(BYTE_NEWLINE, 1'b0, 1'b0);
    endtask

    // separators, one hit per token, both clears together, file start mid-token
    task automatic test_delimiters_and_clears();
        set_pattern(PAT_W'(16'h7978), 5'd2);
        send_byte("x", 1'b1, 1'b1);
        send_byte("y", 1'b0, 1'b0);
        send_byte("x", 1'b0, 1'b0);
        send_byte("y", 1'b0, 1'b0);
        send_byte(BYTE_PERIOD, 1'b0, 1'b0);
        send_byte("x", 1'b0, 1'b0);
        send_byte("y", 1'b1, 1'b0);
        send_byte(BYTE_HYPHEN, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(BYTE_NUL, 1'b0, 1'b0);
    endtask

    // oversized length register clamps to the full window; newline as last pattern byte
    task automatic test_full_window();
        logic [PAT_W-1:0] pat;
        for (int k = 0; k < WIN - 1; k++)
            pat[8*k +: 8] = t_byte'(k * 17 + 1);
        pat[8*(WIN-1) +: 8] = BYTE_NEWLINE;
        set_pattern(pat, 5'd31);
        for (int k = 0; k < WIN; k++)
            send_byte(pat[8*k +: 8], 1'b0, 1'b0);
    endtask

    // random words around the pattern, with noise and broken patterns
    task automatic test_random_phases();
        int               phase_len [N_PHASES] = '{2, 1, 3, 0, 16, 5, 31, 17, 4, 8};
        logic [PAT_W-1:0] pat;
        int               n;
        int               cut;
        int               start;
        t_byte            b;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            pat = {$urandom, $urandom, $urandom, $urandom};
            n = (phase_len[ph] > WIN) ? WIN : phase_len[ph];
            for (int k = 0; k < n; k++) begin
                if (ph % 2 == 0) begin
                    b = t_byte'("a") + t_byte'($urandom_range(0, 3));
                end else begin
                    b = t_byte'($urandom_range(1, 255));
                    if (is_separator(b) || b == BYTE_NEWLINE)
                        b = "z";
                end
                pat[8*k +: 8] = b;
            end
            // a NUL inside the pattern can never match
            if (ph == 8)
                pat[8*$urandom_range(0, n - 1) +: 8] = BYTE_NUL;
            set_pattern(pat, PLEN_W'(phase_len[ph]));
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_byte(t_byte'($urandom_range(0, 255)), flag(30), flag(40));
                end else begin
                    repeat ($urandom_range(0, 3)) send_byte(text_byte(), flag(60), flag(60));
                    if ($urandom_range(0, 2) != 0) begin
                        cut = (n > 1 && flag(5)) ? $urandom_range(1, n - 1) : n;
                        for (int k = 0; k < cut; k++)
                            send_byte(cfg_pattern[8*k +: 8], flag(80), flag(80));
                    end
                    repeat ($urandom_range(0, 2)) send_byte(text_byte(), flag(60), flag(60));
                    // now and then a token longer than the window
                    if (flag(10))
                        repeat ($urandom_range(10, 20)) send_byte(text_byte(), 1'b0, 1'b0);
                    case ($urandom_range(0, 7))
                        0: send_byte(BYTE_SPACE, flag(40), flag(60));
                        1: send_byte(BYTE_COMMA, flag(40), flag(60));
                        2: send_byte(BYTE_PERIOD, flag(40), flag(60));
                        3: send_byte(BYTE_HYPHEN, flag(40), flag(60));
                        4, 5: send_byte(BYTE_NEWLINE, flag(40), flag(60));
                        6: send_byte(BYTE_NUL, flag(40), flag(60));
                        default: ;
                    endcase
                end
            end
        end
    endtask

    // receiver backpressure: each stall style holds for a random run, then a new one is drawn
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
            rx_bits = 8'($urandom) | 8'h01;
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:    out_ch.ready <= 1'b1;
            RX_COIN:    out_ch.ready <= flag(2);
            RX_PATTERN: out_ch.ready <= rx_bits[rx_left % 8];
            default:    out_ch.ready <= flag(6);
        endcase
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing expected", out_ch.match_count, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.token_hit !== want.token_hit)
                    report_mismatch("token_hit", out_ch.token_hit, want.token_hit);
                if (out_ch.match_count !== want.match_count)
                    report_mismatch("match_count", out_ch.match_count, want.match_count);
                if (out_ch.token_active !== want.token_active)
                    report_mismatch("token_active", out_ch.token_active, want.token_active);
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.file_start  = 1'b0;
        in_ch.clear_count = 1'b0;
        out_ch.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_wdata       = '0;
        i_rst_n           = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_pattern();
        test_delimiters_and_clears();
        test_full_window();
        test_random_phases();

        drain_results();
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== token_substring_match_counter.f =====
src/tsmc_pkg.sv
src/tsmc_in_if.sv
src/tsmc_out_if.sv
src/tsmc_cfg_regs.sv
src/tsmc_token_core.sv
src/token_substring_match_counter.sv
sim/token_substring_match_counter_tb.sv
